/* rtl/tpaf_pkg.sv */
// ----------------------------------------------------------------------------
// TRIAC phase-angle firing: shared definitions
// Register indexes, mode codes, widths and reset values for the firing block.
// ----------------------------------------------------------------------------
package tpaf_pkg;

  localparam int TimerBitsDef = 16;
  localparam int CfgDataW     = 16;
  localparam int CfgIdxW      = 2;
  localparam int PowerW       = 7;

  localparam logic [PowerW-1:0] PowerOffBelow = 7'd3;
  localparam logic [PowerW-1:0] PowerFullAbove = 7'd97;
  localparam logic [31:0]       PowerSpan     = 32'd100;

  localparam logic [CfgDataW-1:0] TicksPerPctRst = 16'd6400;
  localparam logic [CfgDataW-1:0] PulseWidthRst  = 16'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_POWER       = 2'd0,
    REG_TICKS_PCT   = 2'd1,
    REG_ZC_DELAY    = 2'd2,
    REG_PULSE_WIDTH = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_PHASE = 2'd1,
    MODE_WAIT  = 2'd2,
    MODE_FULL  = 2'd3
  } mode_e;

  // Operating mode from the power setting and the full-on latch.
  function automatic mode_e mode_of(logic [PowerW-1:0] power, logic latched);
    mode_e m;
    if (power < PowerOffBelow) begin
      m = MODE_OFF;
    end else if (power > PowerFullAbove) begin
      m = latched ? MODE_FULL : MODE_WAIT;
    end else begin
      m = MODE_PHASE;
    end
    return m;
  endfunction

endpackage

/* rtl/triac_phase_angle_firing.sv */
// ----------------------------------------------------------------------------
// TRIAC phase-angle firing controller
// Timer, two compare channels and gate logic driven by one tick per item.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one transaction per 4 us timer tick, tdata[0] = sampled
//    mains sync level. Master stream: one transaction per tick with the gate
//    level and the mode status after that tick.
//  - Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
//    high (0 power %, 1 ticks per percent 8.8, 2 zero-cross delay,
//    3 gate pulse width). Write only while no tick is in flight.
//  - Timing: the result of a tick appears in the cycle after its transaction.
//    Throughput: one tick per cycle when not stalled; a tick's timer/compare
//    update is a single pass of logic into the state and output registers.
//  - Stall: the output register holds its result while m_axis_tready is low;
//    s_axis_tready stays high as long as the output register is empty or
//    being drained, so a new tick lands in the same cycle a result leaves.
//  - Reset: timer stopped, gate low, power 0 (off), sync level assumed high,
//    ticks per percent 6400, pulse width 1, output register empty.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing
  import tpaf_pkg::*;
#(
  parameter int TIMER_BITS = TimerBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // tick input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [0] sync_level, [7:1] zero
  // result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata   // [0] gate, [2:1] mode_status, [7:3] zero
);

  localparam int TW = TIMER_BITS;

  // configuration registers
  logic [PowerW-1:0]   power_q;
  logic [CfgDataW-1:0] tpp_q, zcd_q, pw_q;

  // controller state
  logic          sync_prev_q, sync_prev_d;
  logic [TW-1:0] cnt_q, cnt_d;
  logic [TW-1:0] cmp_a_q, cmp_a_d;
  logic [TW-1:0] cmp_b_q, cmp_b_d;
  logic          run_q, run_d;
  logic          gate_q, gate_d;
  logic          peak_q, peak_d;
  logic          latch_q, latch_d;

  // output register
  logic       out_vld_q;
  logic [7:0] out_data_q, out_data_d;

  logic          accept;
  logic          level;
  logic          hit_a, hit_b;
  logic [TW-1:0] cnt_inc;
  logic [TW-1:0] cmp_b_mid;
  logic [31:0]   span;
  logic [31:0]   prod;
  logic [TW-1:0] phase_dly;
  mode_e         mode_pre, mode_post;
  logic          cfg_power;
  logic [PowerW-1:0] power_new;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign level         = s_axis_tdata[0];

  // Phase delay: (100 - power) * ticks_per_percent in 8.8, integer part kept.
  assign span      = PowerSpan - 32'(power_q);
  assign prod      = span * 32'(tpp_q);
  assign phase_dly = TW'(prod >> 8);

  assign cfg_power = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == REG_POWER);
  assign power_new = cfg_data_i[PowerW-1:0];

  always_comb begin
    // advance the timer, then judge both compares on the new count
    cnt_inc  = run_q ? cnt_q + TW'(1) : cnt_q;
    hit_a    = run_q && (cnt_inc == cmp_a_q);
    hit_b    = run_q && (cnt_inc == cmp_b_q);
    mode_pre = mode_of(power_q, latch_q);

    sync_prev_d = level;
    cnt_d       = cnt_inc;
    cmp_a_d     = cmp_a_q;
    run_d       = run_q;
    peak_d      = peak_q;
    latch_d     = latch_q;
    gate_d      = gate_q;
    cmp_b_mid   = cmp_b_q;

    // falling sync edge: arm the zero-crossing compare and start the timer
    if (sync_prev_q && !level && (mode_pre == MODE_PHASE || mode_pre == MODE_WAIT)) begin
      cmp_a_d = cnt_inc + TW'(zcd_q);
      run_d   = 1'b1;
      peak_d  = 1'b1;
    end

    // zero crossing reached: latch full on, or arm the firing point
    if (hit_a) begin
      if (mode_pre == MODE_WAIT) begin
        latch_d = 1'b1;
        run_d   = 1'b0;
      end else begin
        cmp_b_mid = cnt_inc + phase_dly;
        peak_d    = 1'b0;
      end
    end

    cmp_b_d = cmp_b_mid;
    // firing point: raise the gate for one pulse width, then drop it
    if (hit_b) begin
      if (!gate_q) begin
        gate_d  = 1'b1;
        cmp_b_d = cmp_b_mid + TW'(pw_q);
      end else begin
        gate_d = 1'b0;
        if (!peak_d) begin
          run_d = 1'b0;
        end
      end
    end

    mode_post  = mode_of(power_q, latch_d);
    out_data_d = {5'd0, mode_post, gate_d || latch_d};
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= '0;
      tpp_q   <= TicksPerPctRst;
      zcd_q   <= '0;
      pw_q    <= PulseWidthRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_POWER:       power_q <= power_new;
        REG_TICKS_PCT:   tpp_q   <= cfg_data_i;
        REG_ZC_DELAY:    zcd_q   <= cfg_data_i;
        REG_PULSE_WIDTH: pw_q    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // controller state: a power write takes precedence over a tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_prev_q <= 1'b1;
      cnt_q       <= '0;
      cmp_a_q     <= '0;
      cmp_b_q     <= '0;
      run_q       <= 1'b0;
      gate_q      <= 1'b0;
      peak_q      <= 1'b0;
      latch_q     <= 1'b0;
    end else if (cfg_power) begin
      if (power_new < PowerOffBelow) begin
        // off: stop the timer and drop the gate at once
        run_q   <= 1'b0;
        gate_q  <= 1'b0;
        latch_q <= 1'b0;
      end else if (power_new <= PowerFullAbove) begin
        latch_q <= 1'b0;
      end
    end else if (accept) begin
      sync_prev_q <= sync_prev_d;
      cnt_q       <= cnt_d;
      cmp_a_q     <= cmp_a_d;
      cmp_b_q     <= cmp_b_d;
      run_q       <= run_d;
      gate_q      <= gate_d;
      peak_q      <= peak_d;
      latch_q     <= latch_d;
    end
  end

  // output register: load on a tick, clear once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* rtl/tpaf_checker.sv */
// ----------------------------------------------------------------------------
// TRIAC phase-angle firing: port checker
// Watches the stream ports of the firing block and flags broken behavior.
// ----------------------------------------------------------------------------
module tpaf_checker
  import tpaf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // every accepted tick yields a result on the next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick produced no result");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // off mode never drives the gate
  a_off_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_e'(m_axis_tdata[2:1]) == MODE_OFF) |-> !m_axis_tdata[0])
    else $error("gate high in off mode");

  // full-on mode always drives the gate
  a_full_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_e'(m_axis_tdata[2:1]) == MODE_FULL) |-> m_axis_tdata[0])
    else $error("gate low in full-on mode");

endmodule

bind triac_phase_angle_firing tpaf_checker u_tpaf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
